// ===== rtl/sprite_animation_frame_sequencer_top_defines.svh =====
// Assertion macros for the sprite animation frame sequencer.
`ifndef SPRITE_ANIMATION_FRAME_SEQUENCER_TOP_DEFINES_SVH
`define SPRITE_ANIMATION_FRAME_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SAFS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SAFS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SAFS_ASSERT(label, clk, rstn, prop, msg)
`define SAFS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/safs_pkg.sv =====
// Types and constants shared by the sprite animation frame sequencer.
package safs_pkg;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    localparam int ELAPSED_W = 20;
    localparam int ACC_W     = 32;
    localparam int FRAME_W   = 6;
    localparam int SX_W      = 14;
    localparam int SY_W      = 15;
    localparam int PROD_W    = 16;

    localparam int FCOUNT_W = 7;
    localparam int PERIOD_W = 21;
    localparam int OFFX_W   = 5;
    localparam int OFFY_W   = 4;
    localparam int TPR_W    = 5;
    localparam int TILE_W   = 9;

    localparam logic [FCOUNT_W-1:0] FCOUNT_RST = 7'd8;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 21'd200000;
    localparam logic [OFFX_W-1:0]   OFFX_RST   = '0;
    localparam logic [OFFY_W-1:0]   OFFY_RST   = '0;
    localparam logic [TPR_W-1:0]    TPR_RST    = 5'd4;
    localparam logic [TILE_W-1:0]   TILEW_RST  = 9'd64;
    localparam logic [TILE_W-1:0]   TILEH_RST  = 9'd64;

    localparam logic [FCOUNT_W-1:0] FRAME_LIMIT = 7'd64;
    localparam logic [PROD_W-1:0]   SX_MAX      = 16'd16383;
    localparam logic [PROD_W-1:0]   SY_MAX      = 16'd32767;
    localparam logic [2:0]          DIV_LAST    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_CMP,
        ST_DIV,
        ST_MULX,
        ST_MULY,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        REG_FRAME_COUNT,
        REG_TICK_PERIOD,
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_TILES_PER_ROW,
        REG_TILE_WIDTH,
        REG_TILE_HEIGHT
    } reg_idx_t;

endpackage

// ===== rtl/sprite_animation_frame_sequencer_top.sv =====
// Sprite animation frame sequencer: tick accumulator, frame counter, tile origin.
//
//  port group | dir | beat contents
//  s_*        | in  | elapsed_us
//  m_*        | out | frame_index, advanced, source_x, source_y
//  APB        | in  | register writes and reads
//
//  Each beat passes through add, compare, six divide steps, two multiplies,
//  load of the output register and return to idle. The divide of the frame by
//  tiles_per_row runs one bit per cycle on the shared adder.
//  Reset is synchronous on aresetn low and restores the configuration registers,
//  the accumulator, the frame index, the sequencer state and the output valid.
//  A result held by m_tready low stalls the sequencer in its final step.
`include "sprite_animation_frame_sequencer_top_defines.svh"

module sprite_animation_frame_sequencer_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [19:0] elapsed_us
    input  logic [safs_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [5:0] frame_index, [6] advanced, [20:7] source_x, [35:21] source_y
    output logic [safs_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [safs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [safs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [safs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import safs_pkg::*;

    state_t state_reg, state_next;

    logic [FCOUNT_W-1:0] fcount_reg, fcount_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [OFFX_W-1:0]   offx_reg, offx_next;
    logic [OFFY_W-1:0]   offy_reg, offy_next;
    logic [TPR_W-1:0]    tpr_reg, tpr_next;
    logic [TILE_W-1:0]   tilew_reg, tilew_next;
    logic [TILE_W-1:0]   tileh_reg, tileh_next;

    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic                 adv_reg, adv_next;
    logic [FRAME_W-1:0]   quo_reg, quo_next;
    logic [TPR_W-1:0]     rem_reg, rem_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [SX_W-1:0]      sx_reg, sx_next;
    logic [SY_W-1:0]      sy_reg, sy_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 in_beat;
    logic                 out_load;
    logic                 cfg_we;
    reg_idx_t             cfg_idx;

    logic [ACC_W-1:0]     alu_a, alu_b;
    logic                 alu_sub;
    logic [ACC_W:0]       alu_res;
    logic                 alu_carry;

    logic [FRAME_W:0]     mul_a;
    logic [TILE_W-1:0]    mul_b;
    logic [PROD_W-1:0]    mul_p;

    logic [TPR_W-1:0]     tpr_eff;
    logic [FCOUNT_W-1:0]  limit;
    logic [FCOUNT_W-1:0]  frame_inc;
    logic [FRAME_W-1:0]   frame_wrap;
    logic [TPR_W:0]       div_part;
    logic [OFFX_W:0]      col;
    logic [FRAME_W:0]     row;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign in_beat = s_tvalid && s_tready;

    assign tpr_eff    = (tpr_reg == '0) ? TPR_W'(1) : tpr_reg;
    assign limit      = (fcount_reg > FRAME_LIMIT) ? FRAME_LIMIT : fcount_reg;
    assign frame_inc  = {1'b0, frame_reg} + FCOUNT_W'(1);
    assign frame_wrap = (frame_inc >= limit) ? '0 : frame_inc[FRAME_W-1:0];
    assign div_part   = {rem_reg, quo_reg[FRAME_W-1]};
    assign col        = {1'b0, offx_reg} + {1'b0, rem_reg};
    assign row        = {3'b000, offy_reg} + {1'b0, quo_reg};

    // shared add/subtract unit
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_ADD: begin
                alu_a = acc_reg;
                alu_b = {{(ACC_W-ELAPSED_W){1'b0}}, elapsed_reg};
            end
            ST_CMP: begin
                alu_a   = acc_reg;
                alu_b   = {{(ACC_W-PERIOD_W){1'b0}}, period_reg};
                alu_sub = 1'b1;
            end
            ST_DIV: begin
                alu_a   = {{(ACC_W-TPR_W-1){1'b0}}, div_part};
                alu_b   = {{(ACC_W-TPR_W){1'b0}}, tpr_eff};
                alu_sub = 1'b1;
            end
            default: ;
        endcase
    end

    assign alu_res   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + {{ACC_W{1'b0}}, alu_sub};
    assign alu_carry = alu_res[ACC_W];

    // shared multiplier
    always_comb begin
        if (state_reg == ST_MULY) begin
            mul_a = row;
            mul_b = tileh_reg;
        end else begin
            mul_a = {1'b0, col};
            mul_b = tilew_reg;
        end
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_ADD;
            ST_ADD:  state_next = ST_CMP;
            ST_CMP:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == DIV_LAST) state_next = ST_MULX;
            ST_MULX: state_next = ST_MULY;
            ST_MULY: state_next = ST_DONE;
            ST_DONE: if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    end

    // datapath and registers
    always_comb begin
        fcount_next   = fcount_reg;
        period_next   = period_reg;
        offx_next     = offx_reg;
        offy_next     = offy_reg;
        tpr_next      = tpr_reg;
        tilew_next    = tilew_reg;
        tileh_next    = tileh_reg;
        elapsed_next  = elapsed_reg;
        acc_next      = acc_reg;
        frame_next    = frame_reg;
        adv_next      = adv_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;

        if (cfg_we) begin
            unique case (cfg_idx)
                REG_FRAME_COUNT:   fcount_next = pwdata[FCOUNT_W-1:0];
                REG_TICK_PERIOD:   period_next = pwdata[PERIOD_W-1:0];
                REG_OFFSET_X:      offx_next   = pwdata[OFFX_W-1:0];
                REG_OFFSET_Y:      offy_next   = pwdata[OFFY_W-1:0];
                REG_TILES_PER_ROW: tpr_next    = pwdata[TPR_W-1:0];
                REG_TILE_WIDTH:    tilew_next  = pwdata[TILE_W-1:0];
                REG_TILE_HEIGHT:   tileh_next  = pwdata[TILE_W-1:0];
                default: ;
            endcase
        end

        if (in_beat) begin
            elapsed_next = s_tdata[ELAPSED_W-1:0];
        end

        case (state_reg)
            ST_ADD: begin
                acc_next = alu_carry ? {ACC_W{1'b1}} : alu_res[ACC_W-1:0];
            end
            ST_CMP: begin
                rem_next = '0;
                cnt_next = '0;
                if (alu_carry && (alu_res[ACC_W-1:0] != '0)) begin
                    acc_next   = alu_res[ACC_W-1:0];
                    adv_next   = 1'b1;
                    frame_next = frame_wrap;
                    quo_next   = frame_wrap;
                end else begin
                    adv_next = 1'b0;
                    quo_next = frame_reg;
                end
            end
            ST_DIV: begin
                rem_next = alu_carry ? alu_res[TPR_W-1:0] : div_part[TPR_W-1:0];
                quo_next = {quo_reg[FRAME_W-2:0], alu_carry};
                cnt_next = cnt_reg + 3'd1;
            end
            ST_MULX: begin
                sx_next = (mul_p > SX_MAX) ? SX_MAX[SX_W-1:0] : mul_p[SX_W-1:0];
            end
            ST_MULY: begin
                sy_next = (mul_p > SY_MAX) ? SY_MAX[SY_W-1:0] : mul_p[SY_W-1:0];
            end
            default: ;
        endcase

        if (out_load) begin
            m_tdata_next  = {4'b0000, sy_reg, sx_reg, adv_reg, frame_reg};
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fcount_reg   <= FCOUNT_RST;
            period_reg   <= PERIOD_RST;
            offx_reg     <= OFFX_RST;
            offy_reg     <= OFFY_RST;
            tpr_reg      <= TPR_RST;
            tilew_reg    <= TILEW_RST;
            tileh_reg    <= TILEH_RST;
            acc_reg      <= '0;
            frame_reg    <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fcount_reg   <= fcount_next;
            period_reg   <= period_next;
            offx_reg     <= offx_next;
            offy_reg     <= offy_next;
            tpr_reg      <= tpr_next;
            tilew_reg    <= tilew_next;
            tileh_reg    <= tileh_next;
            acc_reg      <= acc_next;
            frame_reg    <= frame_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        elapsed_reg <= elapsed_next;
        adv_reg     <= adv_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        m_tdata_reg <= m_tdata_next;
    end

    // register readback
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_FRAME_COUNT:   prdata = {{(APB_DATA_W-FCOUNT_W){1'b0}}, fcount_reg};
            REG_TICK_PERIOD:   prdata = {{(APB_DATA_W-PERIOD_W){1'b0}}, period_reg};
            REG_OFFSET_X:      prdata = {{(APB_DATA_W-OFFX_W){1'b0}}, offx_reg};
            REG_OFFSET_Y:      prdata = {{(APB_DATA_W-OFFY_W){1'b0}}, offy_reg};
            REG_TILES_PER_ROW: prdata = {{(APB_DATA_W-TPR_W){1'b0}}, tpr_reg};
            REG_TILE_WIDTH:    prdata = {{(APB_DATA_W-TILE_W){1'b0}}, tilew_reg};
            REG_TILE_HEIGHT:   prdata = {{(APB_DATA_W-TILE_W){1'b0}}, tileh_reg};
            default:           prdata = '0;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SAFS_ASSERT_NEXT(a_busy_after_beat, aclk, aresetn, in_beat, !s_tready,
        "ready after beat")
    `SAFS_ASSERT(a_load_from_done, aclk, aresetn,
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE), "result not from final step")
    `SAFS_ASSERT(a_div_count, aclk, aresetn,
        (state_reg == ST_DIV) |-> (cnt_reg <= DIV_LAST), "divide count overrun")

endmodule

// ===== tb/sv/safs_frame_monitor.sv =====
// Monitor for the sprite frame sequencer: mirrors registers and state, checks each result beat.
`timescale 1ns / 100ps

module safs_frame_monitor (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [safs_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [safs_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [safs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [safs_pkg::APB_DATA_W-1:0]   pwdata,
    input  logic                              pready,
    output int                                fail_count,
    output int                                pending
);
    import safs_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - SY_W - SX_W - FRAME_W - 1;

    typedef struct packed {
        logic [PAD_W-1:0]   pad;
        logic [SY_W-1:0]    source_y;
        logic [SX_W-1:0]    source_x;
        logic               advanced;
        logic [FRAME_W-1:0] frame_index;
    } frame_beat_t;

    logic [FCOUNT_W-1:0] frame_count_r;
    logic [PERIOD_W-1:0] period_r;
    logic [OFFX_W-1:0]   offset_x_r;
    logic [OFFY_W-1:0]   offset_y_r;
    logic [TPR_W-1:0]    tiles_per_row_r;
    logic [TILE_W-1:0]   tile_width_r;
    logic [TILE_W-1:0]   tile_height_r;
    logic [ACC_W-1:0]    acc_us;
    logic [FRAME_W-1:0]  cur_frame;

    frame_beat_t predicted_frames[$];

    task automatic step_animation(input logic [ELAPSED_W-1:0] elapsed, output frame_beat_t beat);
        logic [ACC_W:0] sum;
        int unsigned    lim, nxt, tpr, col, row, px, py;
        beat = '0;
        sum = {1'b0, acc_us} + elapsed;
        acc_us = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
        if (acc_us > period_r) begin
            acc_us = acc_us - period_r;
            beat.advanced = 1'b1;
            lim = (frame_count_r > FRAME_LIMIT) ? 32'(FRAME_LIMIT) : 32'(frame_count_r);
            nxt = cur_frame + 1;
            cur_frame = (nxt >= lim) ? '0 : nxt[FRAME_W-1:0];
        end
        tpr = (tiles_per_row_r == 0) ? 1 : tiles_per_row_r;
        col = offset_x_r + cur_frame % tpr;
        row = offset_y_r + cur_frame / tpr;
        px = col * tile_width_r;
        py = row * tile_height_r;
        beat.frame_index = cur_frame;
        beat.source_x = (px > SX_MAX) ? SX_W'(SX_MAX) : SX_W'(px);
        beat.source_y = (py > SY_MAX) ? SY_W'(SY_MAX) : SY_W'(py);
    endtask

    task automatic check_field(input string field_name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, field_name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        frame_beat_t want;
        frame_beat_t got;
        if (!aresetn) begin
            frame_count_r = FCOUNT_RST;
            period_r = PERIOD_RST;
            offset_x_r = OFFX_RST;
            offset_y_r = OFFY_RST;
            tiles_per_row_r = TPR_RST;
            tile_width_r = TILEW_RST;
            tile_height_r = TILEH_RST;
            acc_us = '0;
            cur_frame = '0;
            fail_count = 0;
            predicted_frames.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (predicted_frames.size() == 0) begin
                    $display("%0t ns: result beat %h with no tick outstanding", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = predicted_frames.pop_front();
                    check_field("frame_index", want.frame_index, got.frame_index);
                    check_field("advanced", want.advanced, got.advanced);
                    check_field("source_x", want.source_x, got.source_x);
                    check_field("source_y", want.source_y, got.source_y);
                    check_field("tdata pad", want.pad, got.pad);
                end
            end
            if (s_tvalid && s_tready) begin
                step_animation(s_tdata[ELAPSED_W-1:0], want);
                predicted_frames.push_back(want);
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_FRAME_COUNT:   frame_count_r = pwdata[FCOUNT_W-1:0];
                    REG_TICK_PERIOD:   period_r = pwdata[PERIOD_W-1:0];
                    REG_OFFSET_X:      offset_x_r = pwdata[OFFX_W-1:0];
                    REG_OFFSET_Y:      offset_y_r = pwdata[OFFY_W-1:0];
                    REG_TILES_PER_ROW: tiles_per_row_r = pwdata[TPR_W-1:0];
                    REG_TILE_WIDTH:    tile_width_r = pwdata[TILE_W-1:0];
                    REG_TILE_HEIGHT:   tile_height_r = pwdata[TILE_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = predicted_frames.size();
    end

endmodule

// ===== tb/sv/sprite_animation_frame_sequencer_top_tb.sv =====
// Testbench top for the sprite frame sequencer: clock, reset, tick and register stimulus, verdict.
`timescale 1ns / 100ps

module sprite_animation_frame_sequencer_top_tb;
    import safs_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 600000;
    localparam int unsigned RANDOM_PHASES   = 8;
    localparam int unsigned TICKS_PER_PHASE = 180;
    localparam int unsigned SAT_TICKS       = 200;
    localparam int unsigned SETTLE_CYCLES   = 24;
    localparam int unsigned ELAPSED_MAX     = (1 << ELAPSED_W) - 1;
    localparam int unsigned PERIOD_MAX      = (1 << PERIOD_W) - 1;
    localparam logic [2:0]  REG_UNMAPPED    = 3'd7;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int          fail_count;
    int          pending;
    int unsigned cycles = 0;
    int unsigned period_us = PERIOD_RST;
    bit          quiet = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    sprite_animation_frame_sequencer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    safs_frame_monitor u_monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int unsigned stall;
        @(posedge aresetn);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    task automatic send_tick(input logic [ELAPSED_W-1:0] elapsed);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_TDATA_W-ELAPSED_W){1'b0}}, elapsed};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] index, input int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic program_regs(input int unsigned fc, input int unsigned per,
                                input int unsigned ox, input int unsigned oy,
                                input int unsigned tpr, input int unsigned tw,
                                input int unsigned th);
        apb_write(REG_FRAME_COUNT, fc);
        apb_write(REG_TICK_PERIOD, per);
        apb_write(REG_OFFSET_X, ox);
        apb_write(REG_OFFSET_Y, oy);
        apb_write(REG_TILES_PER_ROW, tpr);
        apb_write(REG_TILE_WIDTH, tw);
        apb_write(REG_TILE_HEIGHT, th);
        period_us = per;
    endtask

    function automatic logic [ELAPSED_W-1:0] pick_elapsed(input int unsigned span);
        if ($urandom_range(0, 15) == 0)
            return '0;
        return ELAPSED_W'($urandom_range(0, (span > ELAPSED_MAX) ? ELAPSED_MAX : span));
    endfunction

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        send_tick('0);
        settle();
        apb_write(REG_TICK_PERIOD, 0);
        send_tick('0);
        send_tick(ELAPSED_W'(1));
        settle();
        apb_write(REG_TICK_PERIOD, PERIOD_RST);
        apb_write(REG_UNMAPPED, '1);
        send_tick(ELAPSED_W'(PERIOD_RST - 1));
        send_tick(ELAPSED_W'(1));
        send_tick(ELAPSED_W'(ELAPSED_MAX));
        send_tick(20'h55555);
        send_tick(20'hAAAAA);
        repeat (6) send_tick(ELAPSED_W'(PERIOD_RST + 1));
        settle();
        program_regs(127, 1000, 31, 15, 0, 511, 511);
        repeat (4) send_tick(ELAPSED_W'(ELAPSED_MAX));
        settle();
        apb_write(REG_FRAME_COUNT, 0);
        repeat (2) send_tick(ELAPSED_W'(ELAPSED_MAX));

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            // bleed the accumulator so a short period does not start saturated with advances
            settle();
            apb_write(REG_TICK_PERIOD, PERIOD_MAX);
            repeat (4) send_tick('0);
            settle();
            case (p)
                0: program_regs(1, 2000000, 16, 12, 16, 384, 384);
                1: program_regs(64, 1000, 0, 0, 1, 1, 1);
                2: program_regs(127, 1000, 31, 15, 0, 511, 511);
                3: program_regs(0, PERIOD_MAX, 5, 3, 31, 0, 0);
                default: program_regs($urandom_range(0, 127), $urandom_range(1000, PERIOD_MAX),
                                      $urandom_range(0, 31), $urandom_range(0, 15),
                                      $urandom_range(0, 31), $urandom_range(0, 511),
                                      $urandom_range(0, 511));
            endcase
            repeat (TICKS_PER_PHASE) begin
                if ($urandom_range(0, 31) == 0)
                    quiet = !quiet;
                send_tick(pick_elapsed(period_us));
            end
        end

        settle();
        quiet = 1'b1;
        program_regs(64, 0, 2, 1, 8, 100, 50);
        repeat (SAT_TICKS) send_tick(ELAPSED_W'(ELAPSED_MAX));
        settle();
        quiet = 1'b0;
        apb_write(REG_TICK_PERIOD, PERIOD_MAX);
        repeat (8) send_tick(pick_elapsed(ELAPSED_MAX));

        settle();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/safs_pkg.sv
rtl/sprite_animation_frame_sequencer_top.sv
tb/sv/safs_frame_monitor.sv
tb/sv/sprite_animation_frame_sequencer_top_tb.sv
